[hdl/hrps_pkg.sv]
// shared types and constants for the heading rotated position stepper
// no dependencies; imported by every module of the block
package hrps_pkg;

   localparam int POS_W    = 32;
   localparam int STEP_W   = 20;
   localparam int COEF_W   = 16;
   localparam int TERM_W   = 22;
   localparam int PROD_W   = 37;
   localparam int HEAD_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [STEP_W-1:0] STEP_RESET = 20'd6554;

   localparam logic KIND_STEP = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Z = 2'd2;

   typedef struct packed {
      logic                    kind;
      logic [1:0]              axis;
      logic                    forward;
      logic [HEAD_W-1:0]       heading;
      logic signed [POS_W-1:0] load_x;
      logic signed [POS_W-1:0] load_y;
      logic signed [POS_W-1:0] load_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } rsp_payload_type;

   // after the table read: magnitudes and sign flags of sine and cosine
   typedef struct packed {
      logic                     kind;
      logic [1:0]               axis;
      logic                     forward;
      logic signed [COEF_W-1:0] sin_mag;
      logic                     sin_neg;
      logic signed [COEF_W-1:0] cos_mag;
      logic                     cos_neg;
      logic signed [POS_W-1:0]  load_x;
      logic signed [POS_W-1:0]  load_y;
      logic signed [POS_W-1:0]  load_z;
   } stage1_type;

   // after the products: planar increments already shifted down
   typedef struct packed {
      logic                     kind;
      logic [1:0]               axis;
      logic                     forward;
      logic signed [TERM_W-1:0] term_x;
      logic signed [TERM_W-1:0] term_y;
      logic signed [POS_W-1:0]  load_x;
      logic signed [POS_W-1:0]  load_y;
      logic signed [POS_W-1:0]  load_z;
   } stage2_type;

endpackage

[hdl/hrps_sine_rom.sv]
// quarter-wave sine table with registered two-address read, first stage
// depends on hrps_pkg; table contents are built at elaboration
module hrps_sine_rom #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                     clock,
   input  logic                     en,
   input  hrps_pkg::req_payload_type req,
   output hrps_pkg::stage1_type     s1_ff
);
   import hrps_pkg::*;

   localparam int QBITS = ANGLE_BITS - 2;
   localparam int QSIZE = 1 << QBITS;
   localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] LOW32       = 64'h00000000FFFFFFFF;
   localparam logic [63:0] COS_DIV [1:11] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
        64'd306, 64'd380, 64'd462};
   localparam logic [63:0] SIN_DIV [1:11] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
        64'd342, 64'd420, 64'd506};

   typedef logic signed [COEF_W-1:0] rom_type [0:QSIZE];

   // (a * b) >> 62 from 32-bit partial products
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [63:0] p00, p01, p10, p11, mid, lo, hi;
      p00 = (a & LOW32) * (b & LOW32);
      p01 = (a & LOW32) * (b >> 32);
      p10 = (a >> 32) * (b & LOW32);
      p11 = (a >> 32) * (b >> 32);
      mid = (p00 >> 32) + (p01 & LOW32) + (p10 & LOW32);
      lo  = (mid << 32) | (p00 & LOW32);
      hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
      return (hi << 2) | (lo >> 62);
   endfunction

   function automatic logic [63:0] angle_q62(logic [63:0] q);
      logic [63:0] lowmask;
      lowmask = (64'd1 << QBITS) - 64'd1;
      return (HALF_PI_Q62 >> QBITS) * q + (((HALF_PI_Q62 & lowmask) * q) >> QBITS);
   endfunction

   // taylor series for angles up to a quarter of a half turn
   function automatic logic [63:0] series_q62(logic [63:0] y, logic want_cos);
      logic [63:0] y2, t, sum;
      y2  = mul_q62(y, y);
      t   = want_cos ? ONE_Q62 : y;
      sum = t;
      for (int n = 1; n <= 11; n++) begin
         if (want_cos) begin
            t = mul_q62(t, y2) / COS_DIV[n];
         end else begin
            t = mul_q62(t, y2) / SIN_DIV[n];
         end
         if (n % 2 == 1) begin
            sum = sum - t;
         end else begin
            sum = sum + t;
         end
      end
      return sum;
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] s, r;
      for (int q = 0; q <= QSIZE; q++) begin
         if (2 * q <= QSIZE) begin
            s = series_q62(angle_q62(64'(q)), 1'b0);
         end else begin
            s = series_q62(angle_q62(64'(QSIZE - q)), 1'b1);
         end
         r = (s >> 16) * 64'd32767;
         rom[q] = COEF_W'((r + (64'd1 << 45)) >> 46);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [ANGLE_BITS-1:0] ang_s, ang_c;
   logic [QBITS:0]        idx_s, idx_c;

   // cosine is the sine a quarter turn ahead
   assign ang_s = ANGLE_BITS'(req.heading);
   assign ang_c = ang_s + ANGLE_BITS'(QSIZE);

   // odd quadrants read the table mirrored
   assign idx_s = ang_s[ANGLE_BITS-2] ? (QBITS+1)'(QSIZE) - {1'b0, ang_s[QBITS-1:0]}
                                      : {1'b0, ang_s[QBITS-1:0]};
   assign idx_c = ang_c[ANGLE_BITS-2] ? (QBITS+1)'(QSIZE) - {1'b0, ang_c[QBITS-1:0]}
                                      : {1'b0, ang_c[QBITS-1:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff.kind    <= req.kind;
         s1_ff.axis    <= req.axis;
         s1_ff.forward <= req.forward;
         s1_ff.sin_mag <= SINE_ROM[idx_s];
         s1_ff.sin_neg <= ang_s[ANGLE_BITS-1];
         s1_ff.cos_mag <= SINE_ROM[idx_c];
         s1_ff.cos_neg <= ang_c[ANGLE_BITS-1];
         s1_ff.load_x  <= req.load_x;
         s1_ff.load_y  <= req.load_y;
         s1_ff.load_z  <= req.load_z;
      end
   end

endmodule

[hdl/hrps_rotate.sv]
// rotation stage: picks coefficients per axis, multiplies by the step length
// depends on hrps_pkg; fed by hrps_sine_rom
module hrps_rotate (
   input  logic                            clock,
   input  logic                            en,
   input  hrps_pkg::stage1_type            s1,
   input  logic [hrps_pkg::STEP_W-1:0]     step_x,
   input  logic [hrps_pkg::STEP_W-1:0]     step_y,
   output hrps_pkg::stage2_type            s2_ff
);
   import hrps_pkg::*;

   logic signed [COEF_W-1:0] sin_v, cos_v, coef_x, coef_y;
   logic [STEP_W-1:0]        step;
   logic signed [STEP_W:0]   step_s;
   logic signed [PROD_W-1:0] prod_x, prod_y;

   always_comb begin
      sin_v = s1.sin_neg ? -s1.sin_mag : s1.sin_mag;
      cos_v = s1.cos_neg ? -s1.cos_mag : s1.cos_mag;
      // sideways moves along (-sin, cos), forward along (cos, sin)
      if (s1.axis == AXIS_Y) begin
         coef_x = -sin_v;
         coef_y = cos_v;
         step   = step_y;
      end else begin
         coef_x = cos_v;
         coef_y = sin_v;
         step   = step_x;
      end
      step_s = $signed({1'b0, step});
      prod_x = PROD_W'(coef_x) * PROD_W'(step_s);
      prod_y = PROD_W'(coef_y) * PROD_W'(step_s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff.kind    <= s1.kind;
         s2_ff.axis    <= s1.axis;
         s2_ff.forward <= s1.forward;
         s2_ff.term_x  <= TERM_W'(prod_x >>> 15);
         s2_ff.term_y  <= TERM_W'(prod_y >>> 15);
         s2_ff.load_x  <= s1.load_x;
         s2_ff.load_y  <= s1.load_y;
         s2_ff.load_z  <= s1.load_z;
      end
   end

endmodule

[hdl/hrps_accum.sv]
// setpoint registers with saturating update and the result register
// depends on hrps_pkg; fed by hrps_rotate
module hrps_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        out_en,
   input  logic                        update,
   input  hrps_pkg::stage2_type        s2,
   input  logic [hrps_pkg::STEP_W-1:0] step_z,
   output hrps_pkg::rsp_payload_type   pos_ff
);
   import hrps_pkg::*;

   logic signed [POS_W-1:0] set_x_ff, set_y_ff, set_z_ff;
   logic signed [POS_W-1:0] set_x_in, set_y_in, set_z_in;
   logic signed [POS_W-1:0] z_sum;

   function automatic logic signed [POS_W-1:0] sat_step(
      logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b, logic add);
      logic signed [POS_W:0] r;
      r = add ? (POS_W+1)'(a) + (POS_W+1)'(b) : (POS_W+1)'(a) - (POS_W+1)'(b);
      // overflow when the two top bits disagree
      if (r[POS_W] != r[POS_W-1]) begin
         return r[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return r[POS_W-1:0];
   endfunction

   always_comb begin
      set_x_in = set_x_ff;
      set_y_in = set_y_ff;
      z_sum    = set_z_ff;
      set_z_in = set_z_ff;
      if (s2.kind == KIND_LOAD) begin
         set_x_in = s2.load_x;
         set_y_in = s2.load_y;
         set_z_in = s2.load_z;
      end else begin
         case (s2.axis) inside
            AXIS_X, AXIS_Y: begin
               set_x_in = sat_step(set_x_ff, POS_W'(s2.term_x), s2.forward);
               set_y_in = sat_step(set_y_ff, POS_W'(s2.term_y), s2.forward);
            end
            AXIS_Z: z_sum = sat_step(set_z_ff, $signed(POS_W'(step_z)), s2.forward);
            default: ;
         endcase
         // every step item keeps z at or above the floor
         set_z_in = z_sum[POS_W-1] ? '0 : z_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_x_ff <= '0;
         set_y_ff <= '0;
         set_z_ff <= '0;
      end else if (update) begin
         set_x_ff <= set_x_in;
         set_y_ff <= set_y_in;
         set_z_ff <= set_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         pos_ff.pos_x <= set_x_in;
         pos_ff.pos_y <= set_y_in;
         pos_ff.pos_z <= set_z_in;
      end
   end

endmodule

[hdl/heading_rotated_position_stepper_unit.sv]
// heading rotated position stepper, top level: step-size registers and flow control
// word accepted to rsp_valid: registered through table read, multiply, then accumulate
// throughput: one word per cycle unless rsp_ready stalls a full pipe, set by the three-stage pipe; empty slots collapse
// a new word is taken while a result waits as long as a stage ahead is free
// reset (synchronous): setpoint zero, step sizes 6554, pipe empty
// depends on hrps_pkg, hrps_sine_rom, hrps_rotate, hrps_accum
module heading_rotated_position_stepper_unit #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hrps_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hrps_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_we,
   input  logic [hrps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hrps_pkg::STEP_W-1:0]       csr_wdata
);
   import hrps_pkg::*;

   logic [STEP_W-1:0] step_x_ff, step_y_ff, step_z_ff;
   logic              v1_ff, v2_ff, rsp_valid_ff;
   logic              en1, en2, out_en;
   stage1_type        s1;
   stage2_type        s2;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff <= STEP_RESET;
         step_y_ff <= STEP_RESET;
         step_z_ff <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_X: step_x_ff <= csr_wdata;
            CSR_STEP_Y: step_y_ff <= csr_wdata;
            CSR_STEP_Z: step_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage moves when the one after it is empty or moving
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign en2       = !v2_ff || out_en;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   hrps_sine_rom #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_rom (
      .clock (clock),
      .en    (en1),
      .req   (req_payload),
      .s1_ff (s1)
   );

   hrps_rotate u_rot (
      .clock  (clock),
      .en     (en2),
      .s1     (s1),
      .step_x (step_x_ff),
      .step_y (step_y_ff),
      .s2_ff  (s2)
   );

   hrps_accum u_acc (
      .clock  (clock),
      .reset  (reset),
      .out_en (out_en),
      .update (v2_ff && out_en),
      .s2     (s2),
      .step_z (step_z_ff),
      .pos_ff (rsp_payload)
   );

endmodule
